// ===== rtl/core/cfr_pkg.sv =====
// Shared types and constants for the command frame receiver.
// No dependencies; every other file in rtl/core imports this package.
package cfr_pkg;

  // Parse phases
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;
  localparam logic [2:0] PH_END   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_BAD_END = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] START_BYTE_RST = 8'hAA;
  localparam logic [7:0] END_BYTE_RST   = 8'h55;

  // Commands that update a loop gain
  localparam logic [7:0] CMD_P = 8'h50;
  localparam logic [7:0] CMD_I = 8'h49;
  localparam logic [7:0] CMD_D = 8'h44;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command_code;
    logic [7:0]  target_id;
    logic [15:0] payload_value;
    logic        gain_update;
    logic [7:0]  expected_checksum;
    logic [7:0]  offending_byte;
  } result_t;

  // Handshake between the input stage and the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_slot_t;

endpackage

// ===== rtl/core/cfr_if.sv =====
// Channel interfaces of the command frame receiver: byte input, result, config.
// Depends on cfr_pkg for the register index width.
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  command_code;
  logic [7:0]  target_id;
  logic [15:0] payload_value;
  logic        gain_update;
  logic [7:0]  expected_checksum;
  logic [7:0]  offending_byte;
  modport source (output valid, output status, output command_code, output target_id,
                  output payload_value, output gain_update, output expected_checksum,
                  output offending_byte, input ready);
  modport sink   (input valid, input status, input command_code, input target_id,
                  input payload_value, input gain_update, input expected_checksum,
                  input offending_byte, output ready);
endinterface

interface cfr_cfg_if import cfr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [7:0]           wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/core/cfr_in_stage.sv =====
// Input register of the receiver: holds one received byte for the parser.
// Depends on cfr_pkg and cfr_byte_if.
module cfr_in_stage
  import cfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cfr_byte_if.sink      rx,
  input  logic          take,
  output byte_slot_t    slot
);

  logic       valid;
  logic [7:0] rx_byte;

  // Accept a new byte when empty or when the held one leaves this cycle
  assign rx.ready = !valid || take;

  // Hold the byte until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      rx_byte <= rx.rx_byte;
    end
  end

  assign slot.valid   = valid;
  assign slot.rx_byte = rx_byte;

endmodule

// ===== rtl/core/cfr_parser.sv =====
// Frame parser: phase register, held frame bytes, checksum and result build.
// Also holds the start and end byte registers. Depends on cfr_pkg, cfr_cfg_if.
module cfr_parser
  import cfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cfr_cfg_if.sink    cfg,
  input  byte_slot_t slot,
  input  logic       advance,
  output logic       res_valid,
  output result_t    res
);

  logic [7:0]  start_byte;
  logic [7:0]  end_byte;
  logic [2:0]  parse_phase;
  logic [2:0]  parse_phase_next;
  logic [7:0]  held_command;
  logic [7:0]  held_id;
  logic [15:0] held_value;
  logic        value_byte_index;
  logic [7:0]  frame_sum;
  logic        gain;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      end_byte   <= END_BYTE_RST;
    end else if (cfg.valid) begin
      if (cfg.reg_index == CFG_START_BYTE) begin
        start_byte <= cfg.wr_data;
      end else if (cfg.reg_index == CFG_END_BYTE) begin
        end_byte <= cfg.wr_data;
      end
    end
  end

  // Eight-bit additive checksum over the held frame bytes
  assign frame_sum = held_command + held_id + held_value[7:0] + held_value[15:8];
  assign gain = (held_command == CMD_P) || (held_command == CMD_I) ||
                (held_command == CMD_D);

  // Decode the current byte against the phase
  always_comb begin
    parse_phase_next      = parse_phase;
    res_valid             = 1'b0;
    res.status            = ST_OK;
    res.command_code      = held_command;
    res.target_id         = held_id;
    res.payload_value     = held_value;
    res.gain_update       = 1'b0;
    res.expected_checksum = frame_sum;
    res.offending_byte    = slot.rx_byte;
    case (parse_phase)
      PH_HUNT: begin
        if (slot.rx_byte == start_byte) begin
          parse_phase_next = PH_CMD;
        end
      end
      PH_CMD:   parse_phase_next = PH_ID;
      PH_ID:    parse_phase_next = PH_VALUE;
      PH_VALUE: begin
        if (value_byte_index) begin
          parse_phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (slot.rx_byte == frame_sum) begin
          parse_phase_next = PH_END;
        end else begin
          parse_phase_next = PH_HUNT;
          res_valid        = slot.valid;
          res.status       = ST_BAD_SUM;
        end
      end
      PH_END: begin
        parse_phase_next = PH_HUNT;
        res_valid        = slot.valid;
        if (slot.rx_byte == end_byte) begin
          res.status      = ST_OK;
          res.gain_update = gain;
        end else begin
          res.status = ST_BAD_END;
        end
      end
      default: parse_phase_next = PH_HUNT;
    endcase
  end

  // Advance the phase when the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HUNT;
      value_byte_index <= 1'b0;
      held_command     <= '0;
      held_id          <= '0;
      held_value       <= '0;
    end else if (advance) begin
      parse_phase <= parse_phase_next;
      case (parse_phase)
        PH_HUNT: begin
          if (slot.rx_byte == start_byte) begin
            value_byte_index <= 1'b0;
          end
        end
        PH_CMD: held_command <= slot.rx_byte;
        PH_ID:  held_id <= slot.rx_byte;
        PH_VALUE: begin
          if (value_byte_index) begin
            held_value[15:8] <= slot.rx_byte;
          end else begin
            held_value[7:0] <= slot.rx_byte;
          end
          value_byte_index <= !value_byte_index;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/cfr_out_stage.sv =====
// Result register of the receiver: holds one result until the sink takes it.
// Depends on cfr_pkg and cfr_result_if.
module cfr_out_stage
  import cfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  result_t       load_res,
  output logic          can_load,
  cfr_result_if.source  res
);

  logic    valid;
  result_t held;

  // Free when empty or when the held result transfers this cycle
  assign can_load = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= load_res;
    end
  end

  assign res.valid             = valid;
  assign res.status            = held.status;
  assign res.command_code      = held.command_code;
  assign res.target_id         = held.target_id;
  assign res.payload_value     = held.payload_value;
  assign res.gain_update       = held.gain_update;
  assign res.expected_checksum = held.expected_checksum;
  assign res.offending_byte    = held.offending_byte;

endmodule

// ===== rtl/core/command_frame_receiver_unit.sv =====
// Command frame receiver top level: input register, parser, result register.
// The result register loads a result when the parser takes the byte that closes it.
// Throughput: one byte per cycle unless a result is blocked; parsing is combinational.
// Reset (rst, synchronous): parser hunts for the start byte, start/end bytes 0xAA/0x55.
// Depends on cfr_pkg, cfr_if, cfr_in_stage, cfr_parser, cfr_out_stage.
module command_frame_receiver_unit
  import cfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cfr_byte_if.sink      rx,
  cfr_result_if.source  res,
  cfr_cfg_if.sink       cfg
);

  byte_slot_t slot;
  logic       take;
  logic       parse_valid;
  result_t    parse_res;
  logic       can_load;

  // Consume the held byte unless its result cannot be stored
  assign take = slot.valid && (!parse_valid || can_load);

  cfr_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .slot (slot)
  );

  cfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .slot      (slot),
    .advance   (take),
    .res_valid (parse_valid),
    .res       (parse_res)
  );

  cfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && parse_valid),
    .load_res (parse_res),
    .can_load (can_load),
    .res      (res)
  );

endmodule

// ===== tb/command_frame_receiver_checker.sv =====
// Frame checker for command_frame_receiver_unit: tracks the parse state and compares results.
// Depends on cfr_pkg and the channel interfaces in cfr_if.
`timescale 1ns / 1ps

module command_frame_receiver_checker
  import cfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  cfr_byte_if   rx,
  cfr_result_if res,
  cfr_cfg_if    cfg,
  output int    fail_count,
  output int    frames_due
);

  logic [7:0]  start_code;
  logic [7:0]  end_code;
  logic [2:0]  phase;
  logic [7:0]  cmd_held;
  logic [7:0]  id_held;
  logic [15:0] value_held;
  logic        high_half_next;
  result_t     frame_results_due[$];
  int          errors = 0;

  assign fail_count = errors;

  // 8-bit additive checksum over the held frame bytes
  function automatic logic [7:0] held_sum();
    return cmd_held + id_held + value_held[7:0] + value_held[15:8];
  endfunction

  // Advance the parse state by one received byte; queue a result if one falls out
  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    logic    emit;
    emit = 1'b0;
    r    = '0;
    case (phase)
      PH_HUNT: begin
        if (b == start_code) begin
          high_half_next = 1'b0;
          phase          = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_held = b;
        phase    = PH_ID;
      end
      PH_ID: begin
        id_held = b;
        phase   = PH_VALUE;
      end
      PH_VALUE: begin
        if (!high_half_next) begin
          value_held[7:0] = b;
          high_half_next  = 1'b1;
        end else begin
          value_held[15:8] = b;
          high_half_next   = 1'b0;
          phase            = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b == held_sum()) begin
          phase = PH_END;
        end else begin
          phase            = PH_HUNT;
          emit             = 1'b1;
          r.status         = ST_BAD_SUM;
          r.offending_byte = b;
        end
      end
      PH_END: begin
        phase            = PH_HUNT;
        emit             = 1'b1;
        r.offending_byte = b;
        if (b == end_code) begin
          r.status      = ST_OK;
          r.gain_update = (cmd_held == CMD_P) || (cmd_held == CMD_I) || (cmd_held == CMD_D);
        end else begin
          r.status = ST_BAD_END;
        end
      end
      // unreachable phase codes: drop the byte and go back to hunting
      default: phase = PH_HUNT;
    endcase
    if (emit) begin
      r.command_code      = cmd_held;
      r.target_id         = id_held;
      r.payload_value     = value_held;
      r.expected_checksum = held_sum();
      frame_results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Compare one result transfer with the oldest queued frame result
  task automatic check_result();
    result_t want;
    if (frame_results_due.size() == 0) begin
      errors++;
      $display("%0t: result with none due, expected nothing, got status %0h cmd %0h",
               $time, res.status, res.command_code);
    end else begin
      want = frame_results_due.pop_front();
      check_field("status", want.status, res.status);
      check_field("command_code", want.command_code, res.command_code);
      check_field("target_id", want.target_id, res.target_id);
      check_field("payload_value", want.payload_value, res.payload_value);
      check_field("gain_update", want.gain_update, res.gain_update);
      check_field("expected_checksum", want.expected_checksum, res.expected_checksum);
      check_field("offending_byte", want.offending_byte, res.offending_byte);
    end
  endtask

  // Watch all three channels on every rising edge
  always @(posedge clk) begin
    if (rst) begin
      start_code     = START_BYTE_RST;
      end_code       = END_BYTE_RST;
      phase          = PH_HUNT;
      cmd_held       = '0;
      id_held        = '0;
      value_held     = '0;
      high_half_next = 1'b0;
      frame_results_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          CFG_START_BYTE: start_code = cfg.wr_data;
          CFG_END_BYTE:   end_code   = cfg.wr_data;
          default:        ;
        endcase
      end
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
      if (res.valid && res.ready) check_result();
    end
    frames_due <= frame_results_due.size();
  end

endmodule

// ===== tb/command_frame_receiver_unit_tb.sv =====
// Top of the command_frame_receiver_unit testbench: clock, reset, byte and config stimulus.
// Depends on cfr_pkg, cfr_if, the RTL top and command_frame_receiver_checker.
`timescale 1ns / 1ps

module command_frame_receiver_unit_tb;
  import cfr_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_BYTES    = 160;

  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END} frame_kind_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       calm = 1'b0;
  logic [7:0] cur_start = START_BYTE_RST;
  logic [7:0] cur_end   = END_BYTE_RST;
  int         phase_bytes;
  int         ready_hold = 0;
  int         cycle_count = 0;
  int         fail_count;
  int         frames_due;

  cfr_byte_if   rx_ch ();
  cfr_result_if res_ch ();
  cfr_cfg_if    cfg_ch ();

  command_frame_receiver_unit uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  command_frame_receiver_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .res        (res_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .frames_due (frames_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel after transfers and now and then while idle
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      ready_hold = calm ? 0 : $urandom_range(0, 11);
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      ready_hold = $urandom_range(1, 11);
    end
    res_ch.ready <= (ready_hold == 0);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic send_packet(input logic [7:0] cmd, input logic [7:0] id,
                             input logic [15:0] value, input frame_kind_t kind);
    logic [7:0] sum;
    sum = cmd + id + value[7:0] + value[15:8];
    send_byte(cur_start);
    send_byte(cmd);
    send_byte(id);
    send_byte(value[7:0]);
    send_byte(value[15:8]);
    if (kind == FRAME_BAD_SUM) begin
      send_byte(sum + 8'($urandom_range(1, 255)));
    end else begin
      send_byte(sum);
      if (kind == FRAME_BAD_END) send_byte(cur_end ^ 8'($urandom_range(1, 255)));
      else send_byte(cur_end);
    end
  endtask

  // One random frame, mostly well formed, sometimes broken or plain noise
  task automatic send_random_frame();
    int         pick;
    int         n;
    logic [7:0] cmd;
    calm = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 9);
    if (pick >= 8) begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0:       cmd = CMD_P;
        1:       cmd = CMD_I;
        2:       cmd = CMD_D;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      send_packet(cmd, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  pick == 6 ? FRAME_BAD_SUM : (pick == 7 ? FRAME_BAD_END : FRAME_GOOD));
    end
  endtask

  // Write one register, then idle the channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_START_BYTE) cur_start = data;
    else if (idx == CFG_END_BYTE) cur_end = data;
    @(posedge clk);
  endtask

  // Drop valid, wait for every due result, then let the pipeline empty
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    rst              <= 1'b1;
    rx_ch.valid      <= 1'b0;
    rx_ch.rx_byte    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= CFG_START_BYTE;
    cfg_ch.wr_data   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: noise while hunting, start byte as data, gain commands, sum wrap, bad sum/end
    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(CMD_P, cur_start, 16'h0000, FRAME_GOOD);
    send_packet(CMD_I, 8'hFF, 16'hFFFF, FRAME_BAD_SUM);
    send_packet(CMD_D, 8'h00, 16'h00FF, FRAME_BAD_END);
    settle();

    // Random phases, each under its own start/end setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin s = 8'h00; e = 8'hFF; end
        1: begin s = 8'hFF; e = 8'h00; end
        2: begin s = 8'($urandom_range(0, 255)); e = s; end
        3: begin s = START_BYTE_RST; e = END_BYTE_RST; end
        default: begin
          s = 8'($urandom_range(0, 255));
          e = ($urandom_range(0, 2) == 0) ? s : 8'($urandom_range(0, 255));
        end
      endcase
      if (p % 2 == 1) write_reg(CFG_IDX_SPARE_A, 8'($urandom_range(0, 255)));
      else write_reg(CFG_IDX_SPARE_B, 8'($urandom_range(0, 255)));
      write_reg(CFG_START_BYTE, s);
      write_reg(CFG_END_BYTE, e);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_frame();
      calm = 1'b0;
      settle();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
